FILE: rtl/qbmes_pkg.sv
package qbmes_pkg;

	localparam int COORD_W     = 16;
	localparam int T_W         = 17;
	localparam int DIST_W      = 36;
	localparam int ROOT_W      = DIST_W / 2;
	localparam int SPLIT_W     = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam int MAX_POINTS_DEF  = 1024;
	localparam int T_FRAC_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_MID_X   = 3'd2,
		CFG_MID_Y   = 3'd3,
		CFG_END_X   = 3'd4,
		CFG_END_Y   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		BK_RUN,
		BK_ROOT
	} back_state_t;

	typedef struct packed {
		logic [DIST_W-1:0] dsq;
		logic              last;
	} dist_entry_t;

endpackage

FILE: rtl/qbmes_front.sv
module qbmes_front #(
	parameter int T_FRAC_BITS = qbmes_pkg::T_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [qbmes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qbmes_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                  push,
	input  logic signed [qbmes_pkg::COORD_W-1:0]  sample_x,
	input  logic signed [qbmes_pkg::COORD_W-1:0]  sample_y,
	input  logic [qbmes_pkg::T_W-1:0]             param_t,
	input  logic                                  last_sample,
	input  logic                                  stall,
	output logic                                  ent_valid,
	output qbmes_pkg::dist_entry_t                ent
);

	localparam int TF   = T_FRAC_BITS;
	localparam int WW   = TF + 1;
	localparam int TW   = (qbmes_pkg::T_W > WW) ? qbmes_pkg::T_W : WW;
	localparam int CW   = qbmes_pkg::COORD_W;
	localparam int PW   = WW + 1 + CW;
	localparam int SW   = PW + 2;
	localparam int XW   = CW + 1;
	localparam int DW   = CW + 2;
	localparam int QW   = qbmes_pkg::DIST_W;

	localparam logic [TW-1:0]      ONE_T  = TW'(1) << TF;
	localparam logic [WW-1:0]      ONE_W  = WW'(1) << TF;
	localparam logic [2*WW-1:0]    HALF_2 = (2*WW)'(1) << (TF - 1);
	localparam logic signed [SW-1:0] HALF_S = SW'(1) << (TF - 1);

	logic signed [CW-1:0] p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic                 last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic signed [CW-1:0] sx_s1, sx_s2, sx_s3, sx_s4, sx_s5;
	logic signed [CW-1:0] sy_s1, sy_s2, sy_s3, sy_s4, sy_s5;
	logic [WW-1:0]        t_s1, u_s1;
	logic [2*WW-1:0]      tt_s2, uu_s2;
	logic [WW-1:0]        w0_s3, w1_s3, w2_s3;
	logic signed [PW-1:0] px0_s4, px1_s4, px2_s4, py0_s4, py1_s4, py2_s4;
	logic signed [XW-1:0] cx_s5, cy_s5;
	logic signed [DW-1:0] dx_s6, dy_s6;
	logic [QW-1:0]        qx_s7, qy_s7;

	logic                 adv;
	logic [TW-1:0]        t_ext, t_clamp;
	logic [2*WW-1:0]      tt_c, uu_c, w0_full, w2_full;
	logic [WW-1:0]        w0_c, w2_c;
	logic signed [PW-1:0] px0_c, px1_c, px2_c, py0_c, py1_c, py2_c;
	logic signed [SW-1:0] nx_c, ny_c, rx_c, ry_c;
	logic signed [QW-1:0] sqx_c, sqy_c;

	assign adv = !stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0x_q <= '0;
			p0y_q <= '0;
			p1x_q <= '0;
			p1y_q <= '0;
			p2x_q <= '0;
			p2y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qbmes_pkg::CFG_START_X: p0x_q <= cfg_data;
				qbmes_pkg::CFG_START_Y: p0y_q <= cfg_data;
				qbmes_pkg::CFG_MID_X:   p1x_q <= cfg_data;
				qbmes_pkg::CFG_MID_Y:   p1y_q <= cfg_data;
				qbmes_pkg::CFG_END_X:   p2x_q <= cfg_data;
				qbmes_pkg::CFG_END_Y:   p2y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		t_ext   = TW'(param_t);
		t_clamp = (t_ext > ONE_T) ? ONE_T : t_ext;
		tt_c    = t_s1 * t_s1;
		uu_c    = u_s1 * u_s1;
		w0_full = uu_s2 + HALF_2;
		w2_full = tt_s2 + HALF_2;
		w0_c    = w0_full[2*TF:TF];
		w2_c    = w2_full[2*TF:TF];
		px0_c   = $signed({1'b0, w0_s3}) * p0x_q;
		px1_c   = $signed({1'b0, w1_s3}) * p1x_q;
		px2_c   = $signed({1'b0, w2_s3}) * p2x_q;
		py0_c   = $signed({1'b0, w0_s3}) * p0y_q;
		py1_c   = $signed({1'b0, w1_s3}) * p1y_q;
		py2_c   = $signed({1'b0, w2_s3}) * p2y_q;
		nx_c    = SW'(px0_s4) + SW'(px1_s4) + SW'(px2_s4);
		ny_c    = SW'(py0_s4) + SW'(py1_s4) + SW'(py2_s4);
		rx_c    = nx_c + HALF_S;
		ry_c    = ny_c + HALF_S;
		sqx_c   = dx_s6 * dx_s6;
		sqy_c   = dy_s6 * dy_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// advance the whole pipe together; hold it all while the queue is full
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_clamp[WW-1:0];
			u_s1    <= ONE_W - t_clamp[WW-1:0];
			sx_s1   <= sample_x;
			sy_s1   <= sample_y;
			last_s1 <= last_sample;

			tt_s2   <= tt_c;
			uu_s2   <= uu_c;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			last_s2 <= last_s1;

			w0_s3   <= w0_c;
			w2_s3   <= w2_c;
			w1_s3   <= ONE_W - w0_c - w2_c;
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			last_s3 <= last_s2;

			px0_s4  <= px0_c;
			px1_s4  <= px1_c;
			px2_s4  <= px2_c;
			py0_s4  <= py0_c;
			py1_s4  <= py1_c;
			py2_s4  <= py2_c;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			last_s4 <= last_s3;

			cx_s5   <= XW'(rx_c >>> TF);
			cy_s5   <= XW'(ry_c >>> TF);
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			last_s5 <= last_s4;

			dx_s6   <= $signed({cx_s5[XW-1], cx_s5}) - $signed({{2{sx_s5[CW-1]}}, sx_s5});
			dy_s6   <= $signed({cy_s5[XW-1], cy_s5}) - $signed({{2{sy_s5[CW-1]}}, sy_s5});
			last_s6 <= last_s5;

			qx_s7   <= $unsigned(sqx_c);
			qy_s7   <= $unsigned(sqy_c);
			last_s7 <= last_s6;
		end
	end

	assign ent_valid = v_s7 && adv;
	assign ent.dsq   = qx_s7 + qy_s7;
	assign ent.last  = last_s7;

endmodule

FILE: rtl/qbmes_queue.sv
module qbmes_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  qbmes_pkg::dist_entry_t wr_data,
	input  logic                   rd,
	output qbmes_pkg::dist_entry_t rd_data,
	output logic                   full,
	output logic                   empty
);

	localparam int DEPTH = qbmes_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	qbmes_pkg::dist_entry_t slot_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wr_data;
	end

endmodule

FILE: rtl/qbmes_isqrt.sv
module qbmes_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [qbmes_pkg::DIST_W-1:0]      value,
	output logic                              done,
	output logic [qbmes_pkg::ROOT_W-1:0]      root
);

	localparam int VW = qbmes_pkg::DIST_W;

	logic [VW-1:0] rem_q, res_q, bit_q;
	logic          busy_q, done_q;
	logic [VW:0]   trial;
	logic          take;

	// one result bit per cycle, highest first
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= VW'(1) << (VW - 2);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial[VW-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[qbmes_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/qbmes_back.sv
module qbmes_back #(
	parameter int MAX_POINTS = qbmes_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  qbmes_pkg::dist_entry_t            q_data,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [qbmes_pkg::ROOT_W-1:0]      max_distance,
	output logic [qbmes_pkg::SPLIT_W-1:0]     split_index
);

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int IW  = $clog2(MAX_POINTS);
	localparam int SW  = (CW > qbmes_pkg::SPLIT_W) ? CW : qbmes_pkg::SPLIT_W;
	localparam int VW  = qbmes_pkg::DIST_W;

	qbmes_pkg::back_state_t state_q, state_d;

	logic [VW-1:0]                   best_q, best_n;
	logic [IW-1:0]                   idx_q, idx_n, idx_cur;
	logic                            found_q, found_n;
	logic [CW-1:0]                   cnt_q, cnt_n;
	logic                            bigger, below_max;
	logic [CW-1:0]                   split_sel;
	logic [SW-1:0]                   split_wide;
	logic [qbmes_pkg::SPLIT_W-1:0]   split_q;
	logic                            out_valid_q;
	logic [qbmes_pkg::ROOT_W-1:0]    out_dist_q;
	logic [qbmes_pkg::SPLIT_W-1:0]   out_split_q;
	logic                            root_start, root_done, load_out;
	logic [qbmes_pkg::ROOT_W-1:0]    root;

	qbmes_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (best_n),
		.done   (root_done),
		.root   (root)
	);

	always_comb begin
		below_max  = cnt_q < CW'(MAX_POINTS);
		idx_cur    = below_max ? cnt_q[IW-1:0] : IW'(MAX_POINTS - 1);
		bigger     = q_data.dsq > best_q;
		best_n     = bigger ? q_data.dsq : best_q;
		idx_n      = bigger ? idx_cur : idx_q;
		found_n    = found_q || bigger;
		cnt_n      = below_max ? cnt_q + 1'b1 : cnt_q;
		split_sel  = found_n ? CW'(idx_n) : (cnt_n >> 1);
		split_wide = SW'(split_sel);
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		root_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			qbmes_pkg::BK_RUN: begin
				q_pop = !q_empty;
				if (!q_empty && q_data.last) begin
					root_start = 1'b1;
					state_d    = qbmes_pkg::BK_ROOT;
				end
			end
			qbmes_pkg::BK_ROOT: begin
				if (root_done && (!out_valid_q || pop)) begin
					load_out = 1'b1;
					state_d  = qbmes_pkg::BK_RUN;
				end
			end
			default: state_d = qbmes_pkg::BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qbmes_pkg::BK_RUN;
			best_q      <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				if (q_data.last) begin
					best_q  <= '0;
					idx_q   <= '0;
					found_q <= 1'b0;
					cnt_q   <= '0;
				end else begin
					best_q  <= best_n;
					idx_q   <= idx_n;
					found_q <= found_n;
					cnt_q   <= cnt_n;
				end
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (root_start)
			split_q <= split_wide[qbmes_pkg::SPLIT_W-1:0];
		if (load_out) begin
			out_dist_q  <= root;
			out_split_q <= split_q;
		end
	end

	assign empty        = !out_valid_q;
	assign max_distance = out_dist_q;
	assign split_index  = out_split_q;

endmodule

FILE: rtl/quadratic_bezier_max_error_scan_top.sv
// Scans sample points against a quadratic Bezier curve given by three control
// points and reports, once per set, the floor square root of the largest
// squared deviation (an integer, no fraction bits) and the index of that
// sample, or half the sample count when no sample deviated at all. Write the
// six control point registers while the block is idle, then push samples,
// marking the final one of each set with last_sample; one result request
// follows each set. Samples enter at one per cycle while full is low: a
// seven-stage front pipeline evaluates the curve and the squared distance, a
// four-entry queue decouples it from the back end, and the back end folds one
// queued distance per cycle into the running maximum while no root is under
// way. A set's last sample occupies the back end during the bit-serial square
// root and until the result register is loaded, which waits while the
// previous result is still unpopped; samples of the next set keep filling the
// queue meanwhile, and full rises only once the queue has filled.
module quadratic_bezier_max_error_scan_top #(
	parameter int MAX_POINTS  = qbmes_pkg::MAX_POINTS_DEF,
	parameter int T_FRAC_BITS = qbmes_pkg::T_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [qbmes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qbmes_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [qbmes_pkg::COORD_W-1:0]  sample_x,
	input  logic signed [qbmes_pkg::COORD_W-1:0]  sample_y,
	input  logic [qbmes_pkg::T_W-1:0]             param_t,
	input  logic                                  last_sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [qbmes_pkg::ROOT_W-1:0]          max_distance,
	output logic [qbmes_pkg::SPLIT_W-1:0]         split_index
);

	qbmes_pkg::dist_entry_t wr_ent, rd_ent;
	logic                   wr_valid;
	logic                   q_full, q_empty, q_pop;

	// the front stalls as a whole whenever the queue cannot take its output
	assign full = q_full;

	qbmes_front #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.param_t     (param_t),
		.last_sample (last_sample),
		.stall       (q_full),
		.ent_valid   (wr_valid),
		.ent         (wr_ent)
	);

	// buffer squared distances while the back end is busy with a root
	qbmes_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr_valid),
		.wr_data (wr_ent),
		.rd      (q_pop),
		.rd_data (rd_ent),
		.full    (q_full),
		.empty   (q_empty)
	);

	// track the maximum, take the root on a set's last sample, hold the result
	qbmes_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (rd_ent),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.max_distance (max_distance),
		.split_index  (split_index)
	);

endmodule
